[sv/dtp_pkg.sv]
`timescale 1ns / 1ps

package dtp_pkg;

	localparam logic [1:0] KIND_PROP    = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
	localparam logic [31:0] TOK_END_NODE   = 32'd2;
	localparam logic [31:0] TOK_PROP       = 32'd3;
	localparam logic [31:0] TOK_NOP        = 32'd4;
	localparam logic [31:0] TOK_END        = 32'd9;

	typedef struct packed {
		logic [31:0] word;
		logic        restart;
	} word_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] node_name_offset;
		logic [31:0] prop_name_offset;
		logic [31:0] value_offset;
		logic [31:0] value_length;
		logic [7:0]  level;
	} event_item_t;

endpackage

[sv/dtp_stream_if.sv]
`timescale 1ns / 1ps

interface dtp_stream_if #(
	parameter type payload_t = logic [0:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/dtp_parse_core.sv]
`timescale 1ns / 1ps

module dtp_parse_core #(
	parameter int MAX_DEPTH = 255
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [31:0]          word,
	input  logic                 restart,
	output logic                 res_valid,
	output dtp_pkg::event_item_t res
);

	localparam int DW = $clog2(MAX_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_TOKEN,
		PH_NAME,
		PH_LEN,
		PH_NAMEOFF,
		PH_PAYLOAD
	} phase_t;

	phase_t      phase_q, phase_d, phase_e;
	logic [29:0] skip_q, skip_d, skip_e;
	logic [31:0] pos_q, pos_e, pos_d;
	logic [DW-1:0] depth_q, depth_d, depth_e;
	logic [31:0] node_q, node_d, node_e;
	logic [31:0] plen_q, plen_d, plen_e;
	logic        stop_q, stop_d, stop_e;
	logic [31:0] val;
	logic        zero_byte;
	logic [31:0] plen_m1;
	logic [DW+7:0] depth_ext;

	always_comb begin
		val = {word[7:0], word[15:8], word[23:16], word[31:24]};
		zero_byte = (word[7:0] == 8'd0) || (word[15:8] == 8'd0) ||
		            (word[23:16] == 8'd0) || (word[31:24] == 8'd0);

		phase_e = restart ? PH_TOKEN : phase_q;
		skip_e  = restart ? '0 : skip_q;
		pos_e   = restart ? '0 : pos_q;
		depth_e = restart ? '0 : depth_q;
		node_e  = restart ? '0 : node_q;
		plen_e  = restart ? '0 : plen_q;
		stop_e  = restart ? 1'b0 : stop_q;

		phase_d = phase_e;
		skip_d  = skip_e;
		pos_d   = pos_e;
		depth_d = depth_e;
		node_d  = node_e;
		plen_d  = plen_e;
		stop_d  = stop_e;
		plen_m1 = plen_e - 32'd1;

		res_valid            = 1'b0;
		res.kind             = dtp_pkg::KIND_PROP;
		res.prop_name_offset = '0;
		res.value_offset     = '0;
		res.value_length     = '0;

		if (!stop_e) begin
			pos_d = pos_e + 32'd4;
			unique case (phase_e)
				PH_TOKEN: begin
					unique case (val)
						dtp_pkg::TOK_BEGIN_NODE: begin
							node_d = pos_d;
							if (depth_e < DW'(MAX_DEPTH)) begin
								depth_d = depth_e + DW'(1);
							end
							phase_d = PH_NAME;
						end
						dtp_pkg::TOK_END_NODE: begin
							if (depth_e != '0) begin
								depth_d = depth_e - DW'(1);
							end
						end
						dtp_pkg::TOK_PROP: begin
							phase_d = PH_LEN;
						end
						dtp_pkg::TOK_NOP: begin
						end
						dtp_pkg::TOK_END: begin
							stop_d    = 1'b1;
							res_valid = 1'b1;
							res.kind  = dtp_pkg::KIND_END;
						end
						default: begin
							stop_d    = 1'b1;
							res_valid = 1'b1;
							res.kind  = dtp_pkg::KIND_UNKNOWN;
						end
					endcase
				end
				PH_NAME: begin
					if (zero_byte) begin
						phase_d = PH_TOKEN;
					end
				end
				PH_LEN: begin
					plen_d  = val;
					phase_d = PH_NAMEOFF;
				end
				PH_NAMEOFF: begin
					res_valid            = 1'b1;
					res.kind             = dtp_pkg::KIND_PROP;
					res.prop_name_offset = val;
					res.value_offset     = pos_d;
					res.value_length     = plen_e;
					if (plen_e == '0) begin
						phase_d = PH_TOKEN;
					end else begin
						skip_d  = plen_m1[31:2];
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					if (skip_e == '0) begin
						phase_d = PH_TOKEN;
					end else begin
						skip_d = skip_e - 30'd1;
					end
				end
				default: begin
					phase_d = PH_TOKEN;
				end
			endcase
		end

		depth_ext            = {8'd0, depth_d};
		res.node_name_offset = node_d;
		res.level            = depth_ext[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TOKEN;
			skip_q  <= '0;
			pos_q   <= '0;
			depth_q <= '0;
			node_q  <= '0;
			plen_q  <= '0;
			stop_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			pos_q   <= pos_d;
			depth_q <= depth_d;
			node_q  <= node_d;
			plen_q  <= plen_d;
			stop_q  <= stop_d;
		end
	end

endmodule

[sv/device_tree_token_parser.sv]
`timescale 1ns / 1ps
// Device tree structure block token parser.
// The words channel takes one raw 32-bit word of the structure block per item,
// first byte in bits 7..0, with restart set on the first word of a new block.
// The events channel gives one item per property, one on the end token and
// one on an unknown token; after the end or an unknown token, words are
// consumed silently until a word with restart set arrives.
// An accepted word is held in an input register; the parse logic updates the
// token phase, offset and depth counters from it, and any event is captured in
// the output register. The parser takes one word per cycle while no stalled
// event blocks the output register; the phase and counter registers advance
// once for each word that leaves the input register.
// When the receiver stalls, a waiting event holds the output register and the
// next word that would give an event waits in the input register; words that
// give no event still pass through. Reset clears the parse state, the depth
// and the offsets, and empties both registers.
module device_tree_token_parser #(
	parameter int MAX_DEPTH = 255
) (
	input logic         clk,
	input logic         arst_n,
	dtp_stream_if.sink   words,
	dtp_stream_if.source events
);

	logic                 valid_s1;
	logic [31:0]          word_s1;
	logic                 restart_s1;
	logic                 res_valid;
	dtp_pkg::event_item_t res;
	logic                 adv;
	logic                 out_valid_q;
	dtp_pkg::event_item_t out_data_q;

	dtp_parse_core #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.word     (word_s1),
		.restart  (restart_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	assign adv          = valid_s1 && (!res_valid || !out_valid_q || events.ready);
	assign words.ready  = !valid_s1 || adv;
	assign events.valid = out_valid_q;
	assign events.data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (words.valid && words.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1    <= words.data.word;
			restart_s1 <= words.data.restart;
		end
		if (adv && res_valid) begin
			out_data_q <= res;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !events.ready |=> out_valid_q && $stable(out_data_q))
		else $error("event lost or changed under stall");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res_valid |-> !out_valid_q || events.ready)
		else $error("event register overwritten");

	a_blocked_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> !words.ready)
		else $error("word taken while input register is blocked");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.kind == dtp_pkg::KIND_PROP ||
		out_data_q.kind == dtp_pkg::KIND_END || out_data_q.kind == dtp_pkg::KIND_UNKNOWN)
		else $error("illegal event kind");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH_LIMIT = 255;
	localparam int IDLE_LIMIT = 2000;
	localparam int STIMULUS_WORDS = 1000;
	localparam int PRESSURE_AT = 700;
	localparam int PRESSURE_CYCLES = 400;

	typedef enum logic [2:0] {
		AT_TOKEN,
		IN_NAME,
		AT_LENGTH,
		AT_NAME_OFFSET,
		IN_PAYLOAD
	} parse_phase_t;

	logic clk;
	logic arst_n;

	dtp_stream_if #(.payload_t(dtp_pkg::word_item_t)) words_if ();
	dtp_stream_if #(.payload_t(dtp_pkg::event_item_t)) events_if ();

	device_tree_token_parser #(
		.MAX_DEPTH(DEPTH_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.words(words_if),
		.events(events_if)
	);

	parse_phase_t cur_phase;
	logic [29:0] words_to_skip;
	logic [31:0] next_offset;
	int depth;
	logic [31:0] node_offset;
	logic [31:0] prop_length;
	bit halted;

	dtp_pkg::word_item_t pending_words[$];
	dtp_pkg::event_item_t expected_events[$];
	dtp_pkg::event_item_t want_ev;
	bit restart_flag;
	bit pressure_done;
	int errors;
	int events_seen;
	int words_taken;
	int total_words;
	int src_gap;
	int src_calm;
	int snk_stall;
	int snk_calm;
	int idle_cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [31:0] swap_bytes(logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic int next_gap(inout int calm);
		int pick;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			calm = $urandom_range(30, 80);
			return 0;
		end
		if (pick < 70)
			return 0;
		if (pick < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] odd_token();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(5, 8);
			default: return $urandom_range(10, 32'h7FFF_FFFF);
		endcase
	endfunction

	task automatic clear_parser();
		cur_phase = AT_TOKEN;
		words_to_skip = '0;
		next_offset = '0;
		depth = 0;
		node_offset = '0;
		prop_length = '0;
		halted = 1'b0;
	endtask

	task automatic parse_word(input dtp_pkg::word_item_t it);
		logic [31:0] val;
		dtp_pkg::event_item_t ev;
		bit fire;
		val = swap_bytes(it.word);
		ev = '0;
		fire = 1'b0;
		if (it.restart)
			clear_parser();
		if (!halted) begin
			next_offset = next_offset + 32'd4;
			case (cur_phase)
				AT_TOKEN: begin
					case (val)
						dtp_pkg::TOK_BEGIN_NODE: begin
							node_offset = next_offset;
							if (depth < DEPTH_LIMIT)
								depth++;
							cur_phase = IN_NAME;
						end
						dtp_pkg::TOK_END_NODE: begin
							if (depth > 0)
								depth--;
						end
						dtp_pkg::TOK_PROP: cur_phase = AT_LENGTH;
						dtp_pkg::TOK_NOP: ;
						dtp_pkg::TOK_END: begin
							halted = 1'b1;
							fire = 1'b1;
							ev.kind = dtp_pkg::KIND_END;
						end
						default: begin
							halted = 1'b1;
							fire = 1'b1;
							ev.kind = dtp_pkg::KIND_UNKNOWN;
						end
					endcase
				end
				IN_NAME: begin
					if (it.word[7:0] == 8'h00 || it.word[15:8] == 8'h00 ||
					    it.word[23:16] == 8'h00 || it.word[31:24] == 8'h00)
						cur_phase = AT_TOKEN;
				end
				AT_LENGTH: begin
					prop_length = val;
					cur_phase = AT_NAME_OFFSET;
				end
				AT_NAME_OFFSET: begin
					fire = 1'b1;
					ev.kind = dtp_pkg::KIND_PROP;
					ev.prop_name_offset = val;
					ev.value_offset = next_offset;
					ev.value_length = prop_length;
					if (prop_length == 32'd0) begin
						cur_phase = AT_TOKEN;
					end else begin
						words_to_skip = 30'((prop_length - 32'd1) >> 2);
						cur_phase = IN_PAYLOAD;
					end
				end
				default: begin
					if (words_to_skip == '0)
						cur_phase = AT_TOKEN;
					else
						words_to_skip = words_to_skip - 30'd1;
				end
			endcase
			if (fire) begin
				ev.node_name_offset = node_offset;
				ev.level = depth[7:0];
				expected_events.push_back(ev);
			end
		end
	endtask

	task automatic put_raw(logic [31:0] raw);
		dtp_pkg::word_item_t it;
		it.word = raw;
		it.restart = restart_flag;
		restart_flag = 1'b0;
		pending_words.push_back(it);
	endtask

	task automatic put_value(logic [31:0] v);
		put_raw(swap_bytes(v));
	endtask

	// Every name word but the last has only nonzero bytes.
	task automatic put_name(int words);
		logic [31:0] w;
		for (int i = 0; i < words; i++) begin
			for (int k = 0; k < 4; k++)
				w[8*k +: 8] = 8'($urandom_range(1, 255));
			if (i == words - 1) begin
				w[8*$urandom_range(0, 3) +: 8] = 8'h00;
				if ($urandom_range(0, 3) == 0)
					w[8*$urandom_range(0, 3) +: 8] = 8'h00;
			end
			put_raw(w);
		end
	endtask

	task automatic put_prop(logic [31:0] len, logic [31:0] name_off, int payload_words);
		put_value(dtp_pkg::TOK_PROP);
		put_value(len);
		put_value(name_off);
		repeat (payload_words)
			put_raw($urandom());
	endtask

	task automatic put_random_block();
		int steps;
		int choice;
		int len;
		restart_flag = 1'b1;
		steps = $urandom_range(3, 25);
		for (int s = 0; s < steps; s++) begin
			choice = $urandom_range(0, 99);
			if (choice < 30) begin
				put_value(dtp_pkg::TOK_BEGIN_NODE);
				put_name($urandom_range(1, 3));
			end else if (choice < 50) begin
				put_value(dtp_pkg::TOK_END_NODE);
			end else if (choice < 85) begin
				len = $urandom_range(0, 20);
				put_prop(len, $urandom(), (len + 3) / 4);
			end else begin
				put_value(dtp_pkg::TOK_NOP);
			end
		end
		choice = $urandom_range(0, 99);
		if (choice < 60)
			put_value(dtp_pkg::TOK_END);
		else if (choice < 75)
			put_value(odd_token());
		else if (choice < 88)
			put_prop($urandom(), $urandom(), $urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4))
				put_raw($urandom());
	endtask

	task automatic put_noise_block();
		restart_flag = 1'b1;
		repeat ($urandom_range(2, 8)) begin
			case ($urandom_range(0, 5))
				0: put_value(dtp_pkg::TOK_BEGIN_NODE);
				1: put_value(dtp_pkg::TOK_END_NODE);
				2: put_value(dtp_pkg::TOK_PROP);
				3: put_value(dtp_pkg::TOK_NOP);
				4: put_value(dtp_pkg::TOK_END);
				default: put_raw($urandom());
			endcase
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 50)
			$display("event %0d: %s is 0x%08h, should be 0x%08h", events_seen, what, got, want);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			words_if.valid <= 1'b0;
			words_if.data <= '0;
			src_gap = 0;
		end else begin
			if (words_if.valid && words_if.ready) begin
				parse_word(words_if.data);
				words_taken <= words_taken + 1;
			end
			if (!words_if.valid || words_if.ready) begin
				if (src_gap > 0) begin
					words_if.valid <= 1'b0;
					src_gap--;
				end else if (pending_words.size() > 0) begin
					words_if.valid <= 1'b1;
					words_if.data <= pending_words.pop_front();
					src_gap = next_gap(src_calm);
				end else begin
					words_if.valid <= 1'b0;
				end
			end
		end
	end

	// The long hold-off lets words that give no event drain in, then the input stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			events_if.ready <= 1'b0;
		end else if (snk_stall > 0) begin
			snk_stall--;
			events_if.ready <= 1'b0;
		end else if (!pressure_done && words_taken >= PRESSURE_AT) begin
			pressure_done = 1'b1;
			snk_stall = PRESSURE_CYCLES - 1;
			events_if.ready <= 1'b0;
		end else begin
			snk_stall = next_gap(snk_calm);
			if (snk_stall == 0) begin
				events_if.ready <= 1'b1;
			end else begin
				events_if.ready <= 1'b0;
				snk_stall--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && events_if.valid && events_if.ready) begin
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected event kind", 32'(events_if.data.kind),
					32'hFFFF_FFFF);
			end else begin
				want_ev = expected_events.pop_front();
				if (events_if.data.kind !== want_ev.kind)
					report_mismatch("kind", 32'(events_if.data.kind), 32'(want_ev.kind));
				if (events_if.data.node_name_offset !== want_ev.node_name_offset)
					report_mismatch("node_name_offset", events_if.data.node_name_offset,
						want_ev.node_name_offset);
				if (events_if.data.prop_name_offset !== want_ev.prop_name_offset)
					report_mismatch("prop_name_offset", events_if.data.prop_name_offset,
						want_ev.prop_name_offset);
				if (events_if.data.value_offset !== want_ev.value_offset)
					report_mismatch("value_offset", events_if.data.value_offset,
						want_ev.value_offset);
				if (events_if.data.value_length !== want_ev.value_length)
					report_mismatch("value_length", events_if.data.value_length,
						want_ev.value_length);
				if (events_if.data.level !== want_ev.level)
					report_mismatch("level", 32'(events_if.data.level), 32'(want_ev.level));
			end
			events_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((words_if.valid && words_if.ready) || (events_if.valid && events_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[device_tree_token_parser] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		words_if.valid = 1'b0;
		words_if.data = '0;
		events_if.ready = 1'b0;
		errors = 0;
		events_seen = 0;
		words_taken = 0;
		src_calm = 0;
		snk_calm = 0;
		snk_stall = 0;
		idle_cycles = 0;
		pressure_done = 1'b0;
		clear_parser();

		restart_flag = 1'b1;
		put_value(dtp_pkg::TOK_BEGIN_NODE);
		put_raw(32'h0000_6261);
		put_value(dtp_pkg::TOK_END_NODE);
		put_value(dtp_pkg::TOK_END_NODE);
		put_value(dtp_pkg::TOK_NOP);
		put_prop(32'd0, 32'hFFFF_FFFF, 0);
		put_value(dtp_pkg::TOK_BEGIN_NODE);
		put_raw(32'hFFFF_FFFF);
		put_raw(32'h0000_0000);
		put_prop(32'd5, 32'd0, 0);
		put_raw(32'hFFFF_FFFF);
		put_raw(32'h0000_0000);
		put_prop(32'd4, 32'd12, 1);
		put_value(32'd0);
		put_value(dtp_pkg::TOK_BEGIN_NODE);
		put_raw($urandom());
		restart_flag = 1'b1;
		put_prop(32'hFFFF_FFFF, 32'd7, 2);
		restart_flag = 1'b1;
		put_value(dtp_pkg::TOK_END);
		restart_flag = 1'b1;
		put_value(32'hFFFF_FFFF);

		// Nest past the depth limit, then step back down.
		restart_flag = 1'b1;
		repeat (DEPTH_LIMIT + 2) begin
			put_value(dtp_pkg::TOK_BEGIN_NODE);
			put_name(1);
		end
		put_prop(32'd0, $urandom(), 0);
		put_value(dtp_pkg::TOK_END_NODE);
		put_value(dtp_pkg::TOK_END_NODE);
		put_prop(32'd1, $urandom(), 1);
		put_value(dtp_pkg::TOK_END);

		while (pending_words.size() < STIMULUS_WORDS) begin
			if ($urandom_range(0, 9) == 0)
				put_noise_block();
			else
				put_random_block();
		end
		total_words = pending_words.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (words_taken < total_words || expected_events.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[device_tree_token_parser] OK");
		else
			$display("[device_tree_token_parser] ERROR");
		$finish;
	end

endmodule
